### rtl/lts_pkg.sv
// Shared types and codes for the lexicographic topological sort block.
`timescale 1ns / 1ps
package lts_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_NODE  = 2'd0;
    localparam logic [1:0] ST_CYCLE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_OVFL  = 2'd3;

    localparam int NODE_W = 10;
    localparam int CFG_W  = 11;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [1:0]        status;
        logic              is_last;
    } t_out;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_edge;

    // controller to datapath
    typedef struct packed {
        logic add_edge;
        logic add_rej;
        logic clear;
        logic cfg_wr;
        logic sort_init;
        logic clr_wr;
        logic cnt_begin;
        logic edge_chk;
        logic deg_upd;
        logic scan_begin;
        logic scan_addr;
        logic scan_chk;
        logic sort_done;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sorted;
        logic add_ok;
        logic etot_end;
        logic ncnt_last;
        logic edge_hit;
        logic found;
    } t_stat;

endpackage

### rtl/lts_ctrl.sv
// Sequencer for edge loading, the sort passes and result delivery.
`timescale 1ns / 1ps
module lts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [1:0]     i_op,
    input  logic           i_cfg_valid,
    input  lts_pkg::t_stat i_stat,
    output lts_pkg::t_cmd  o_cmd,
    output logic           busy,
    output logic           o_cfg_ready
);
    import lts_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_CLR  = 10'b0000000010,
        S_ERD  = 10'b0000000100,
        S_EDG  = 10'b0000001000,
        S_DRD  = 10'b0000010000,
        S_DWR  = 10'b0000100000,
        S_SADR = 10'b0001000000,
        S_SWT  = 10'b0010000000,
        S_SCHK = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.cfg_wr = i_cfg_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_ADD: begin
                            o_cmd.add_edge = i_stat.add_ok;
                            o_cmd.add_rej  = !i_stat.add_ok;
                        end
                        OP_NEXT: begin
                            if (i_stat.sorted) begin
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.sort_init = 1'b1;
                                n_state = S_CLR;
                            end
                        end
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.ncnt_last) begin
                    o_cmd.cnt_begin = 1'b1;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                if (i_stat.etot_end) begin
                    o_cmd.scan_begin = 1'b1;
                    n_state = S_SADR;
                end else begin
                    n_state = S_EDG;
                end
            end
            S_EDG: begin
                o_cmd.edge_chk = 1'b1;
                n_state = i_stat.edge_hit ? S_DRD : S_ERD;
            end
            S_DRD: n_state = S_DWR;
            S_DWR: begin
                o_cmd.deg_upd = 1'b1;
                n_state = S_ERD;
            end
            S_SADR: begin
                o_cmd.scan_addr = 1'b1;
                n_state = S_SWT;
            end
            S_SWT: n_state = S_SCHK;
            S_SCHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_stat.found) begin
                    n_state = S_ERD;
                end else if (i_stat.ncnt_last) begin
                    o_cmd.sort_done = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SADR;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/lts_dp.sv
// Edge store, in-degree store, order buffer, counters and result register.
`timescale 1ns / 1ps
module lts_dp #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lts_pkg::t_in                i_in,
    input  logic [lts_pkg::CFG_W-1:0]   i_cfg_data,
    input  lts_pkg::t_cmd               i_cmd,
    output lts_pkg::t_stat              o_stat,
    output lts_pkg::t_out               o_res,
    output logic                        o_res_stb
);
    import lts_pkg::*;

    localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);

    typedef struct packed {
        logic           done;
        logic [ETW-1:0] deg;
    } t_deg;

    t_edge edge_mem [MAX_EDGES];
    t_deg  deg_mem  [MAX_NODES];
    logic [IW-1:0] ord_mem [MAX_NODES];

    logic [CFG_W-1:0] r_ncfg;
    logic [ETW-1:0]   r_etot;
    logic [ETW-1:0]   r_ecnt;
    logic [IW-1:0]    r_ncnt;
    logic [IW-1:0]    r_daddr;
    logic [IW-1:0]    r_u;
    logic [NCW-1:0]   r_olen;
    logic [NCW-1:0]   r_rp;
    logic             r_sorted;
    logic             r_dec;
    t_edge            r_edge_q;
    t_deg             r_deg_q;
    logic [IW-1:0]    r_ord_q;
    t_out             r_res;
    logic             r_res_stb;

    logic [NCW-1:0] n_live;
    logic           hit;
    logic           found;
    logic           deg_we;
    logic [IW-1:0]  deg_wa;
    t_deg           deg_wd;
    t_out           n_res;

    always_comb begin
        if (r_ncfg == '0) begin
            n_live = NCW'(1);
        end else if (32'(r_ncfg) > 32'(MAX_NODES)) begin
            n_live = NCW'(MAX_NODES);
        end else begin
            n_live = NCW'(r_ncfg);
        end
    end

    always_comb begin
        if (r_dec) begin
            hit = (32'(r_edge_q.src) == 32'(r_u)) && (32'(r_edge_q.dst) < 32'(n_live));
        end else begin
            hit = (32'(r_edge_q.src) < 32'(n_live)) && (32'(r_edge_q.dst) < 32'(n_live));
        end
    end

    assign found = !r_deg_q.done && (r_deg_q.deg == '0);

    assign o_stat.sorted    = r_sorted;
    assign o_stat.add_ok    = (32'(r_etot) < 32'(MAX_EDGES))
                              && (32'(i_in.src_node) < 32'(n_live))
                              && (32'(i_in.dst_node) < 32'(n_live));
    assign o_stat.etot_end  = (r_ecnt == r_etot);
    assign o_stat.ncnt_last = (32'(r_ncnt) + 32'd1 == 32'(n_live));
    assign o_stat.edge_hit  = hit;
    assign o_stat.found     = found;

    // single write port of the in-degree store
    always_comb begin
        deg_we = 1'b0;
        deg_wa = r_daddr;
        deg_wd = r_deg_q;
        if (i_cmd.clr_wr) begin
            deg_we = 1'b1;
            deg_wa = r_ncnt;
            deg_wd = '0;
        end else if (i_cmd.deg_upd) begin
            if (r_dec) begin
                deg_we = (r_deg_q.deg != '0);
                deg_wd.deg = r_deg_q.deg - ETW'(1);
            end else begin
                deg_we = 1'b1;
                deg_wd.deg = r_deg_q.deg + ETW'(1);
            end
        end else if (i_cmd.scan_chk && found) begin
            deg_we = 1'b1;
            deg_wd.done = 1'b1;
        end
    end

    always_comb begin
        n_res = '0;
        if (i_cmd.add_rej) begin
            n_res.status = ST_OVFL;
        end else if (i_cmd.emit) begin
            if (32'(r_olen) < 32'(n_live)) begin
                n_res.status = ST_CYCLE;
            end else if (r_rp >= r_olen) begin
                n_res.status = ST_DONE;
            end else begin
                n_res.status  = ST_NODE;
                n_res.node    = NODE_W'(r_ord_q);
                n_res.is_last = (32'(r_rp) + 32'd1 == 32'(r_olen));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_edge) begin
            edge_mem[EAW'(r_etot)] <= '{src: i_in.src_node, dst: i_in.dst_node};
        end
        r_edge_q <= edge_mem[EAW'(r_ecnt)];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        r_deg_q <= deg_mem[r_daddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_chk && found) begin
            ord_mem[IW'(r_olen)] <= r_ncnt;
        end
        r_ord_q <= ord_mem[IW'(r_rp)];
    end

    // counters and pointers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init || i_cmd.scan_begin) begin
            r_ncnt <= '0;
        end else if (i_cmd.clr_wr || (i_cmd.scan_chk && !found)) begin
            r_ncnt <= r_ncnt + IW'(1);
        end
        if (i_cmd.cnt_begin || (i_cmd.scan_chk && found)) begin
            r_ecnt <= '0;
        end else if ((i_cmd.edge_chk && !hit) || i_cmd.deg_upd) begin
            r_ecnt <= r_ecnt + ETW'(1);
        end
        if (i_cmd.cnt_begin) begin
            r_dec <= 1'b0;
        end else if (i_cmd.scan_chk && found) begin
            r_dec <= 1'b1;
            r_u   <= r_ncnt;
        end
        if (i_cmd.edge_chk) begin
            r_daddr <= IW'(r_edge_q.dst);
        end else if (i_cmd.scan_addr) begin
            r_daddr <= r_ncnt;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncfg    <= CFG_W'(1);
            r_etot    <= '0;
            r_olen    <= '0;
            r_rp      <= '0;
            r_sorted  <= 1'b0;
            r_res_stb <= 1'b0;
        end else begin
            r_res_stb <= i_cmd.add_rej || i_cmd.emit;
            if (i_cmd.cfg_wr) begin
                r_ncfg   <= i_cfg_data;
            end
            if (i_cmd.add_edge) begin
                r_etot <= r_etot + ETW'(1);
            end else if (i_cmd.clear) begin
                r_etot <= '0;
            end
            if (i_cmd.cfg_wr || i_cmd.add_edge || i_cmd.clear || i_cmd.sort_init) begin
                r_sorted <= 1'b0;
                r_rp     <= '0;
            end else if (i_cmd.sort_done) begin
                r_sorted <= 1'b1;
            end else if (i_cmd.emit && (32'(r_olen) >= 32'(n_live)) && (r_rp < r_olen)) begin
                r_rp <= r_rp + NCW'(1);
            end
            if (i_cmd.clear || i_cmd.sort_init) begin
                r_olen <= '0;
            end else if (i_cmd.scan_chk && found) begin
                r_olen <= r_olen + NCW'(1);
            end
        end
    end

    assign o_res     = r_res;
    assign o_res_stb = r_res_stb;

endmodule

### rtl/lexicographic_topological_sort.sv
// Top level of the lexicographic topological sort block.
`timescale 1ns / 1ps
// Usage:
//   Command channel: a beat on i_in is taken when start is high and busy is low.
//   op 0 adds an edge; a rejected edge (store full or endpoint at or above the
//   node count) yields one result with status 3 on the next cycle.
//   op 2 clears the graph, op 3 does nothing; neither gives a result.
//   op 1 returns the next node of the order (status 1 if the graph has a cycle,
//   status 2 once the order is used up). If the order is not current, the sort
//   runs first: a pass clearing the in-degrees, a pass over the stored edges to
//   count them, then for each placed node a scan from node 0 and another edge
//   pass that lowers the in-degrees of that node's successors.
//   Results appear on o_res for one cycle with o_res_stb high; the receiver
//   cannot stall, so no result is ever held back.
//   The node_count register is written through i_cfg_valid / o_cfg_ready while
//   the block is idle; a write drops any computed order.
//   Reset sets node_count to 1 and empties the graph; no clearing pass is needed.
module lexicographic_topological_sort #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lts_pkg::t_in              i_in,
    output lts_pkg::t_out             o_res,
    output logic                      o_res_stb,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lts_pkg::CFG_W-1:0] i_cfg_data
);
    import lts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_op        (i_in.op),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready)
    );

    lts_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res),
        .o_res_stb  (o_res_stb)
    );

endmodule
